// ===== rtl/bmhp_pkg.sv =====
package bmhp_pkg;

    localparam logic [7:0] MARK_LITTLE = 8'h6c;
    localparam logic [7:0] MARK_BIG    = 8'h42;
    localparam logic [7:0] SIG_STRING  = 8'h73;
    localparam logic [7:0] SIG_PATH    = 8'h6f;
    localparam logic [7:0] SIG_UINT    = 8'h75;

    localparam logic [16:0] HDR_BYTES  = 17'd16;
    localparam logic [16:0] HDR_LAST   = 17'd15;
    localparam logic [16:0] LIMIT_INIT = 17'h10000;

    localparam logic [2:0] ROLE_HEADER = 3'd0;
    localparam logic [2:0] ROLE_FRAME  = 3'd1;
    localparam logic [2:0] ROLE_STRING = 3'd2;
    localparam logic [2:0] ROLE_UINT   = 3'd3;
    localparam logic [2:0] ROLE_PAD    = 3'd4;
    localparam logic [2:0] ROLE_BODY   = 3'd5;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_MARK = 2'd1;
    localparam logic [1:0] ERR_SIZE = 2'd2;

    typedef enum logic [3:0] {
        PH_CODE,
        PH_SIGLEN,
        PH_SIG,
        PH_SIGPAD,
        PH_STRLEN,
        PH_STRBYTES,
        PH_STRZERO,
        PH_U32,
        PH_TRAILPAD,
        PH_SKIP
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [7:0]  code;
        logic [7:0]  sig_count;
        logic [15:0] sig_chars;
        logic [31:0] remaining;
        logic [31:0] word;
    } field_state_t;

    typedef struct packed {
        logic [2:0]  role;
        logic [7:0]  code;
        logic [31:0] word;
        logic        valid;
    } field_out_t;

endpackage

// ===== rtl/bmhp_field_step.sv =====
module bmhp_field_step
(
    input  bmhp_pkg::field_state_t st,
    input  logic [7:0]             data,
    input  logic [16:0]            rel,
    input  logic [31:0]            len,
    output bmhp_pkg::field_state_t st_next,
    output bmhp_pkg::field_out_t   res
);

    logic [17:0]      n;
    logic [33:0]      n_w;
    logic [33:0]      len_w;
    logic             n_aligned;
    logic             value_fits;
    logic [7:0]       cnt_next;
    logic [15:0]      chars_next;
    logic             known;
    logic [1:0]       idx;
    logic [31:0]      word_next;
    logic [2:0]       left_next;
    bmhp_pkg::phase_t phase_sig;
    bmhp_pkg::phase_t phase_pad;

    always_comb
    begin
        n          = 18'(rel) + 18'd1;
        n_w        = 34'(n);
        len_w      = 34'(len);
        n_aligned  = (n[2:0] == 3'd0);
        value_fits = (n_w + 34'd4) <= len_w;

        chars_next = st.sig_chars;
        if (st.sig_count == 8'd0)
        begin
            chars_next[7:0] = st.sig_chars[7:0] | data;
        end
        else if (st.sig_count == 8'd1)
        begin
            chars_next[15:8] = st.sig_chars[15:8] | data;
        end
        cnt_next = (st.sig_count != 8'hff) ? st.sig_count + 8'd1 : st.sig_count;
        known = (cnt_next >= 8'd2) && (chars_next[15:8] == 8'd0) &&
                (chars_next[7:0] == bmhp_pkg::SIG_STRING ||
                 chars_next[7:0] == bmhp_pkg::SIG_PATH ||
                 chars_next[7:0] == bmhp_pkg::SIG_UINT);
        phase_sig = (chars_next[7:0] == bmhp_pkg::SIG_UINT) ? bmhp_pkg::PH_U32
                                                            : bmhp_pkg::PH_STRLEN;
        phase_pad = (st.sig_chars[7:0] == bmhp_pkg::SIG_UINT) ? bmhp_pkg::PH_U32
                                                              : bmhp_pkg::PH_STRLEN;

        // little-endian word, first byte lowest
        idx       = 2'(3'd4 - st.remaining[2:0]);
        word_next = st.word | (32'(data) << {idx, 3'b000});
        left_next = st.remaining[2:0] - 3'd1;

        st_next   = st;
        res.role  = bmhp_pkg::ROLE_FRAME;
        res.code  = st.code;
        res.word  = 32'd0;
        res.valid = 1'b0;

        unique case (st.phase)
            bmhp_pkg::PH_CODE:
            begin
                if ((34'(rel) + 34'd4) > len_w)
                begin
                    st_next.phase = bmhp_pkg::PH_SKIP;
                    res.role      = bmhp_pkg::ROLE_PAD;
                    res.code      = 8'd0;
                end
                else
                begin
                    st_next.code  = data;
                    res.code      = data;
                    st_next.phase = bmhp_pkg::PH_SIGLEN;
                end
            end
            bmhp_pkg::PH_SIGLEN:
            begin
                if (data == 8'd0 || (n_w + 34'(data)) > len_w)
                begin
                    st_next.phase = bmhp_pkg::PH_SKIP;
                end
                else
                begin
                    st_next.sig_count = 8'd0;
                    st_next.sig_chars = 16'd0;
                    st_next.remaining = 32'(data);
                    st_next.phase     = bmhp_pkg::PH_SIG;
                end
            end
            bmhp_pkg::PH_SIG:
            begin
                st_next.sig_chars = chars_next;
                st_next.sig_count = cnt_next;
                st_next.remaining = st.remaining - 32'd1;
                if (st.remaining == 32'd1)
                begin
                    if (!known)
                    begin
                        st_next.phase = bmhp_pkg::PH_SKIP;
                    end
                    else if (!n_aligned)
                    begin
                        st_next.phase = bmhp_pkg::PH_SIGPAD;
                    end
                    else if (value_fits)
                    begin
                        st_next.remaining = 32'd4;
                        st_next.word      = 32'd0;
                        st_next.phase     = phase_sig;
                    end
                    else
                    begin
                        st_next.phase = bmhp_pkg::PH_SKIP;
                    end
                end
            end
            bmhp_pkg::PH_SIGPAD:
            begin
                res.role = bmhp_pkg::ROLE_PAD;
                if (n_aligned)
                begin
                    if (value_fits)
                    begin
                        st_next.remaining = 32'd4;
                        st_next.word      = 32'd0;
                        st_next.phase     = phase_pad;
                    end
                    else
                    begin
                        st_next.phase = bmhp_pkg::PH_SKIP;
                    end
                end
            end
            bmhp_pkg::PH_STRLEN:
            begin
                st_next.word      = word_next;
                st_next.remaining = 32'(left_next);
                if (left_next == 3'd0)
                begin
                    res.word  = word_next;
                    res.valid = 1'b1;
                    if ((n_w + 34'(word_next) + 34'd1) > len_w)
                    begin
                        st_next.phase = bmhp_pkg::PH_SKIP;
                    end
                    else if (word_next == 32'd0)
                    begin
                        st_next.phase = bmhp_pkg::PH_STRZERO;
                    end
                    else
                    begin
                        st_next.remaining = word_next;
                        st_next.phase     = bmhp_pkg::PH_STRBYTES;
                    end
                end
            end
            bmhp_pkg::PH_STRBYTES:
            begin
                res.role          = bmhp_pkg::ROLE_STRING;
                st_next.remaining = st.remaining - 32'd1;
                if (st.remaining == 32'd1)
                begin
                    st_next.phase = bmhp_pkg::PH_STRZERO;
                end
            end
            bmhp_pkg::PH_STRZERO:
            begin
                res.role      = bmhp_pkg::ROLE_STRING;
                st_next.phase = n_aligned ? bmhp_pkg::PH_CODE : bmhp_pkg::PH_TRAILPAD;
            end
            bmhp_pkg::PH_U32:
            begin
                res.role          = bmhp_pkg::ROLE_UINT;
                st_next.word      = word_next;
                st_next.remaining = 32'(left_next);
                if (left_next == 3'd0)
                begin
                    res.word      = word_next;
                    res.valid     = 1'b1;
                    st_next.phase = n_aligned ? bmhp_pkg::PH_CODE : bmhp_pkg::PH_TRAILPAD;
                end
            end
            bmhp_pkg::PH_TRAILPAD:
            begin
                res.role = bmhp_pkg::ROLE_PAD;
                if (n_aligned)
                begin
                    st_next.phase = bmhp_pkg::PH_CODE;
                end
            end
            default:
            begin
                st_next.phase = bmhp_pkg::PH_SKIP;
                res.role      = bmhp_pkg::ROLE_PAD;
                res.code      = 8'd0;
            end
        endcase
    end

endmodule

// ===== rtl/bus_message_header_parser_unit.sv =====
// Bus message header parser: one message byte in, one tagged byte out.
// Input channel: in_valid / in_stall with data_byte. A beat is taken at a
// clock edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall carrying byte_out, role, field_code,
// value_word, value_valid, message_last and error, one beat per input beat.
// Configuration: cfg_valid / cfg_ready with size_limit; cfg_ready is always
// high. Write it only while no byte is in flight.
// Each input beat passes through the input register, then the result
// register. Throughput is one byte per cycle while out_stall is low; the
// field walk and header checks sit in the single stage between the two.
// While out_stall is high the result register holds its beat and one more
// byte is taken into the input register; after that in_stall rises.
// Reset clears both stages, returns to the start of a message, clears the
// error and sets size_limit to 65536. An error stays until reset.
module bus_message_header_parser_unit
#(
    parameter int BUFFER_BYTES = 65536
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [16:0] size_limit,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  byte_out,
    output logic [2:0]  role,
    output logic [7:0]  field_code,
    output logic [31:0] value_word,
    output logic        value_valid,
    output logic        message_last,
    output logic [1:0]  error
);

    localparam logic [33:0] BUF_LIMIT = 34'(BUFFER_BYTES);

    logic [16:0] limit_reg;
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        res_valid_reg;
    logic [7:0]  byte_out_reg;
    logic [2:0]  role_reg;
    logic [7:0]  code_reg;
    logic [31:0] word_reg;
    logic        word_valid_reg;
    logic        last_reg;
    logic [1:0]  err_out_reg;

    logic [16:0] pos_reg,      pos_next;
    logic [31:0] fields_reg,   fields_next;
    logic [31:0] body_reg,     body_next;
    logic [32:0] area_end_reg, area_end_next;
    logic [16:0] total_reg,    total_next;
    logic [7:0]  first_reg,    first_next;
    logic [1:0]  err_reg,      err_next;
    bmhp_pkg::field_state_t field_reg, field_next;

    bmhp_pkg::field_state_t walk_state;
    bmhp_pkg::field_out_t   walk_out;

    logic        res_load;
    logic [16:0] rel;
    logic [33:0] total;
    logic [33:0] limit_w;
    logic [16:0] total_eff;
    logic [2:0]  role_next;
    logic [7:0]  code_next;
    logic [31:0] word_next;
    logic        valid_next;
    logic        last_next;

    assign res_load  = in_valid_reg && (!res_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !res_load;
    assign cfg_ready = 1'b1;

    assign out_valid    = res_valid_reg;
    assign byte_out     = byte_out_reg;
    assign role         = role_reg;
    assign field_code   = code_reg;
    assign value_word   = word_reg;
    assign value_valid  = word_valid_reg;
    assign message_last = last_reg;
    assign error        = err_out_reg;

    assign rel = pos_reg - bmhp_pkg::HDR_BYTES;

    bmhp_field_step u_field_step
    (
        .st      (field_reg),
        .data    (in_byte_reg),
        .rel     (rel),
        .len     (fields_reg),
        .st_next (walk_state),
        .res     (walk_out)
    );

    always_comb
    begin
        pos_next      = pos_reg;
        fields_next   = fields_reg;
        body_next     = body_reg;
        area_end_next = area_end_reg;
        total_next    = total_reg;
        first_next    = first_reg;
        err_next      = err_reg;
        field_next    = field_reg;
        role_next     = bmhp_pkg::ROLE_PAD;
        code_next     = 8'd0;
        word_next     = 32'd0;
        valid_next    = 1'b0;
        last_next     = 1'b0;
        total         = '0;
        total_eff     = total_reg;

        limit_w = (34'(limit_reg) < BUF_LIMIT) ? 34'(limit_reg) : BUF_LIMIT;

        if (err_reg == bmhp_pkg::ERR_NONE)
        begin
            if (pos_reg < bmhp_pkg::HDR_BYTES)
            begin
                role_next = bmhp_pkg::ROLE_HEADER;
                if (pos_reg == 17'd0)
                begin
                    first_next = in_byte_reg;
                end
                if (pos_reg[3:2] == 2'd1)
                begin
                    body_next[{pos_reg[1:0], 3'b000} +: 8] = in_byte_reg;
                end
                if (pos_reg[3:2] == 2'd3)
                begin
                    fields_next[{pos_reg[1:0], 3'b000} +: 8] = in_byte_reg;
                end
                if (pos_reg == bmhp_pkg::HDR_LAST)
                begin
                    // end of field area rounded up to 8
                    area_end_next = (33'(fields_next) + 33'd23) & ~33'd7;
                    total         = 34'(area_end_next) + 34'(body_reg);
                    field_next.phase = bmhp_pkg::PH_CODE;
                    field_next.code  = 8'd0;
                    if (first_reg != bmhp_pkg::MARK_LITTLE && first_reg != bmhp_pkg::MARK_BIG)
                    begin
                        err_next = bmhp_pkg::ERR_MARK;
                    end
                    else if (total > limit_w)
                    begin
                        err_next = bmhp_pkg::ERR_SIZE;
                    end
                    else
                    begin
                        total_next = total[16:0];
                    end
                    total_eff = total_next;
                end
            end
            else if (34'(rel) < 34'(fields_reg))
            begin
                field_next = walk_state;
                role_next  = walk_out.role;
                code_next  = walk_out.code;
                word_next  = walk_out.word;
                valid_next = walk_out.valid;
            end
            else if (34'(pos_reg) < 34'(area_end_reg))
            begin
                role_next = bmhp_pkg::ROLE_PAD;
            end
            else
            begin
                role_next = bmhp_pkg::ROLE_BODY;
            end

            if (err_next == bmhp_pkg::ERR_NONE)
            begin
                if (pos_reg >= bmhp_pkg::HDR_LAST &&
                    (18'(pos_reg) + 18'd1) >= 18'(total_eff))
                begin
                    last_next = 1'b1;
                    pos_next  = 17'd0;
                end
                else
                begin
                    pos_next = pos_reg + 17'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= bmhp_pkg::LIMIT_INIT;
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            pos_reg       <= 17'd0;
            fields_reg    <= 32'd0;
            body_reg      <= 32'd0;
            area_end_reg  <= 33'd16;
            total_reg     <= 17'd0;
            first_reg     <= 8'd0;
            err_reg       <= bmhp_pkg::ERR_NONE;
            field_reg     <= '{phase: bmhp_pkg::PH_CODE, default: '0};
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= size_limit;
            end
            if (in_valid && !in_stall)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (res_load)
            begin
                in_valid_reg <= 1'b0;
            end
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && !out_stall)
            begin
                res_valid_reg <= 1'b0;
            end
            if (res_load)
            begin
                pos_reg      <= pos_next;
                fields_reg   <= fields_next;
                body_reg     <= body_next;
                area_end_reg <= area_end_next;
                total_reg    <= total_next;
                first_reg    <= first_next;
                err_reg      <= err_next;
                field_reg    <= field_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_byte_reg <= data_byte;
        end
        if (res_load)
        begin
            byte_out_reg   <= in_byte_reg;
            role_reg       <= role_next;
            code_reg       <= code_next;
            word_reg       <= word_next;
            word_valid_reg <= valid_next;
            last_reg       <= last_next;
            err_out_reg    <= err_next;
        end
    end

`ifndef ASSERT_OFF
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg != bmhp_pkg::ERR_NONE |=> err_reg == $past(err_reg))
        else $error("error code changed after being raised");

    a_pos_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg != bmhp_pkg::ERR_NONE |=> $stable(pos_reg))
        else $error("byte position moved while in error");

    a_value_role: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && word_valid_reg |->
            (role_reg == bmhp_pkg::ROLE_FRAME || role_reg == bmhp_pkg::ROLE_UINT))
        else $error("value reported on a byte of the wrong role");

    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !word_valid_reg |-> word_reg == 32'd0)
        else $error("value word not zero without value_valid");

    a_last_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && last_reg |-> err_out_reg == bmhp_pkg::ERR_NONE)
        else $error("message end marked on an errored beat");
`endif

endmodule
